/* src/mk_pkg.sv */
// Package for the Morse keyer: phase codes, request and result structs,
// Morse timing constants and the letter pattern table. No dependencies.
package mk_pkg;

   // Keying phases.
   typedef enum logic [2:0] {
      PH_IDLE       = 3'd0,
      PH_ON         = 3'd1,
      PH_ELEM_GAP   = 3'd2,
      PH_LETTER_GAP = 3'd3,
      PH_WORD_GAP   = 3'd4
   } phase_type;

   // Request operation codes.
   localparam logic OP_TICK = 1'b0;
   localparam logic OP_LOAD = 1'b1;

   localparam int UNIT_WIDTH  = 13;
   localparam int UNITS_WIDTH = 3;
   localparam int PROD_WIDTH  = UNIT_WIDTH + UNITS_WIDTH;

   localparam logic [UNIT_WIDTH-1:0] UNIT_TICKS_RESET = 13'd100;

   // Interval lengths in Morse units.
   localparam logic [UNITS_WIDTH-1:0] DOT_UNITS        = 3'd1;
   localparam logic [UNITS_WIDTH-1:0] DASH_UNITS       = 3'd3;
   localparam logic [UNITS_WIDTH-1:0] GAP_ELEM_UNITS   = 3'd1;
   localparam logic [UNITS_WIDTH-1:0] GAP_LETTER_UNITS = 3'd3;
   localparam logic [UNITS_WIDTH-1:0] GAP_WORD_UNITS   = 3'd7;
   localparam logic [UNITS_WIDTH-1:0] SPACE_UNITS      = GAP_WORD_UNITS - GAP_LETTER_UNITS;

   localparam logic [7:0] CHAR_A     = 8'h41;
   localparam logic [7:0] CHAR_Z     = 8'h5A;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   // One request as it travels through the input register.
   typedef struct packed {
      logic       operation;
      logic [7:0] char_code;
   } mk_item_type;

   // One result as it travels to the result register.
   typedef struct packed {
      logic key_on;
      logic ready_res;
      logic rejected;
   } mk_result_type;

   // Letter pattern: bits 3:0 mark dashes, bits 6:4 give the element count.
   function automatic logic [6:0] letter_entry(input logic [4:0] idx);
      logic [6:0] entry;
      case (idx)
         5'd0:    entry = 7'h22;
         5'd1:    entry = 7'h41;
         5'd2:    entry = 7'h45;
         5'd3:    entry = 7'h31;
         5'd4:    entry = 7'h10;
         5'd5:    entry = 7'h44;
         5'd6:    entry = 7'h33;
         5'd7:    entry = 7'h40;
         5'd8:    entry = 7'h20;
         5'd9:    entry = 7'h4E;
         5'd10:   entry = 7'h35;
         5'd11:   entry = 7'h42;
         5'd12:   entry = 7'h23;
         5'd13:   entry = 7'h21;
         5'd14:   entry = 7'h37;
         5'd15:   entry = 7'h46;
         5'd16:   entry = 7'h4B;
         5'd17:   entry = 7'h32;
         5'd18:   entry = 7'h30;
         5'd19:   entry = 7'h11;
         5'd20:   entry = 7'h34;
         5'd21:   entry = 7'h48;
         5'd22:   entry = 7'h36;
         5'd23:   entry = 7'h49;
         5'd24:   entry = 7'h4D;
         5'd25:   entry = 7'h43;
         default: entry = 7'h00;
      endcase
      return entry;
   endfunction

endpackage

/* src/mk_core.sv */
// Keying state machine of the Morse keyer: phase, countdown and pattern
// state, updated once per request. Depends on mk_pkg.
module mk_core import mk_pkg::*; #(
   parameter int COUNT_WIDTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step_en,
   input  mk_item_type           item,
   input  logic [UNIT_WIDTH-1:0] unit_ticks,
   output mk_result_type         result
);

   localparam int WIDE_WIDTH = PROD_WIDTH + COUNT_WIDTH;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

   phase_type              phase_ff, phase_in;
   logic [COUNT_WIDTH-1:0] countdown_ff, countdown_in;
   logic [3:0]             pattern_bits_ff, pattern_bits_in;
   logic [2:0]             pattern_length_ff, pattern_length_in;
   logic [2:0]             element_index_ff, element_index_in;

   logic                   is_letter;
   logic                   is_space;
   logic [6:0]             entry;
   logic [4:0]             letter_off;
   logic [COUNT_WIDTH-1:0] count_dec;
   logic [2:0]             next_index;
   logic                   load_interval;
   logic [UNITS_WIDTH-1:0] units;
   logic [UNIT_WIDTH-1:0]  unit_eff;
   logic [PROD_WIDTH-1:0]  product;
   logic [WIDE_WIDTH-1:0]  product_wide;
   logic [COUNT_WIDTH-1:0] interval_ticks;

   // Character decode and pattern lookup.
   assign is_letter  = item.char_code inside {[CHAR_A:CHAR_Z]};
   assign is_space   = (item.char_code == CHAR_SPACE);
   assign letter_off = 5'(item.char_code - CHAR_A);
   assign entry      = letter_entry(letter_off);

   assign count_dec  = countdown_ff - COUNT_WIDTH'(countdown_ff != '0);
   assign next_index = element_index_ff + 3'd1;

   // Interval length: unit length (zero taken as one) times units, saturated.
   assign unit_eff       = (unit_ticks == '0) ? UNIT_WIDTH'(1) : unit_ticks;
   assign product        = PROD_WIDTH'(unit_eff) * PROD_WIDTH'(units);
   assign product_wide   = WIDE_WIDTH'(product);
   assign interval_ticks = (product_wide > WIDE_WIDTH'(COUNT_MAX)) ?
                           COUNT_MAX : product_wide[COUNT_WIDTH-1:0];

   // Next state for one request.
   always_comb begin
      phase_in          = phase_ff;
      countdown_in      = countdown_ff;
      pattern_bits_in   = pattern_bits_ff;
      pattern_length_in = pattern_length_ff;
      element_index_in  = element_index_ff;
      load_interval     = 1'b0;
      units             = DOT_UNITS;
      result.rejected   = 1'b0;
      if (item.operation == OP_LOAD) begin
         if (phase_ff != PH_IDLE) begin
            result.rejected = 1'b1;
         end else if (is_letter) begin
            pattern_bits_in   = entry[3:0];
            pattern_length_in = entry[6:4];
            element_index_in  = 3'd0;
            phase_in          = PH_ON;
            load_interval     = 1'b1;
            units             = entry[0] ? DASH_UNITS : DOT_UNITS;
         end else if (is_space) begin
            phase_in      = PH_WORD_GAP;
            load_interval = 1'b1;
            units         = SPACE_UNITS;
         end
      end else if (phase_ff != PH_IDLE) begin
         countdown_in = count_dec;
         if (count_dec == '0) begin
            case (phase_ff)
               PH_ON: begin
                  element_index_in = next_index;
                  load_interval    = 1'b1;
                  if (next_index >= pattern_length_ff) begin
                     phase_in = PH_LETTER_GAP;
                     units    = GAP_LETTER_UNITS;
                  end else begin
                     phase_in = PH_ELEM_GAP;
                     units    = GAP_ELEM_UNITS;
                  end
               end
               PH_ELEM_GAP: begin
                  phase_in      = PH_ON;
                  load_interval = 1'b1;
                  units = pattern_bits_ff[element_index_ff[1:0]] ? DASH_UNITS : DOT_UNITS;
               end
               default: begin
                  phase_in = PH_IDLE;
               end
            endcase
         end
      end
      if (load_interval) begin
         countdown_in = interval_ticks;
      end
      result.key_on    = (phase_in == PH_ON);
      result.ready_res = (phase_in == PH_IDLE);
   end

   // State registers, advanced once per request.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= PH_IDLE;
         countdown_ff      <= '0;
         pattern_bits_ff   <= '0;
         pattern_length_ff <= '0;
         element_index_ff  <= '0;
      end else if (step_en) begin
         phase_ff          <= phase_in;
         countdown_ff      <= countdown_in;
         pattern_bits_ff   <= pattern_bits_in;
         pattern_length_ff <= pattern_length_in;
         element_index_ff  <= element_index_in;
      end
   end

   // A busy keyer always has time left in its current interval.
   a_busy_has_count: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != PH_IDLE) |-> (countdown_ff != '0))
      else $error("keyer busy with an empty countdown");

   // A load that arrives while busy leaves the state alone.
   a_reject_holds: assert property (@(posedge clock) disable iff (reset)
      (step_en && item.operation == OP_LOAD && phase_ff != PH_IDLE) |=>
      ($stable(phase_ff) && $stable(countdown_ff) && $stable(element_index_ff)))
      else $error("rejected load changed the keyer state");

   // A letter loaded while idle starts keying its first element.
   a_letter_starts: assert property (@(posedge clock) disable iff (reset)
      (step_en && item.operation == OP_LOAD && phase_ff == PH_IDLE && is_letter) |=>
      (phase_ff == PH_ON && element_index_ff == 3'd0))
      else $error("letter load did not start keying");

endmodule

/* src/morse_keyer_top.sv */
// A request moves from the input register to the result register; its result is
// computed as it leaves the input register. Throughput: one request
// per cycle; the input and result registers move together and stall only
// while a held result is stalled. Reset clears the keyer to idle, unit length
// to 100 ticks, and empties both registers.
// Top level of the Morse keyer: input register, keyer core and result
// register, plus the unit length register. Depends on mk_pkg and mk_core.
module morse_keyer_top import mk_pkg::*; #(
   parameter int COUNT_WIDTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_operation,
   input  logic [7:0]            req_char_code,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_key_on,
   output logic                  rsp_ready_res,
   output logic                  rsp_rejected,
   input  logic                  csr_wr_en,
   input  logic [UNIT_WIDTH-1:0] csr_wr_data
);

   logic                  advance;
   logic                  s1_valid_ff, s1_valid_in;
   mk_item_type           s1_item_ff, s1_item_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   mk_result_type         rsp_result_ff;
   mk_result_type         core_result;
   logic [UNIT_WIDTH-1:0] unit_ticks_ff, unit_ticks_in;

   // The whole pipeline moves unless a held result is stalled.
   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;

   assign s1_valid_in          = req_valid;
   assign s1_item_in.operation = req_operation;
   assign s1_item_in.char_code = req_char_code;
   assign rsp_valid_in         = s1_valid_ff;
   assign unit_ticks_in        = csr_wr_data;

   // Unit length register.
   always_ff @(posedge clock) begin
      if (reset) begin
         unit_ticks_ff <= UNIT_TICKS_RESET;
      end else if (csr_wr_en) begin
         unit_ticks_ff <= unit_ticks_in;
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_item_ff <= s1_item_in;
      end
   end

   // Keyer state machine, stepped as a request leaves the input register.
   mk_core #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .step_en    (advance && s1_valid_ff),
      .item       (s1_item_ff),
      .unit_ticks (unit_ticks_ff),
      .result     (core_result)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_result_ff <= core_result;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_key_on    = rsp_result_ff.key_on;
   assign rsp_ready_res = rsp_result_ff.ready_res;
   assign rsp_rejected  = rsp_result_ff.rejected;

endmodule
